[rtl/core/srvn_pkg.sv]
// Shared types, constants and codes of the sparse running-variance normalizer.
`timescale 1ns / 1ps
package srvn_pkg;

    // Field and store widths
    localparam int FEATURES_DEF = 1024;
    localparam int FEAT_W       = 10;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 32;
    localparam int M2_W         = 64;
    localparam int VAR_W        = 48;
    localparam int EPS_W        = 16;
    localparam int FRAC_W       = 16;

    // Shared divider and square-root widths
    localparam int DVD_W        = 64;
    localparam int DSR_W        = 32;
    localparam int RAD_W        = 64;
    localparam int ROOT_W       = 32;

    // Multiplier operand width (magnitude of a 33-bit difference)
    localparam int MAG_W        = 33;
    localparam int PROD_W       = 2 * MAG_W;

    // Configuration port
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;
    localparam int REG_EPSILON  = 0;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Item kinds
    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_NORM = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [FEAT_W-1:0] feature;
        logic [DATA_W-1:0] sample;
    } srvn_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] normalized;
        logic              saturated;
    } srvn_out_t;

    // One statistics entry as kept in the memory
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] mean;
        logic [M2_W-1:0]   m2;
        logic [VAR_W-1:0]  variance;
    } srvn_entry_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_NORM
    } srvn_div_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic          clr_step;
        logic          load;
        logic          prep;
        logic          div_start;
        srvn_div_sel_t div_sel;
        logic          mean_upd;
        logic          m2_upd;
        logic          sqrt_start;
        logic          wr;
        logic          res_load;
    } srvn_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic acc;
        logic in_range;
        logic div_done;
        logic mul_done;
        logic sqrt_done;
        logic out_busy;
    } srvn_status_t;

endpackage

[rtl/core/srvn_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle, shared by all divisions.
`timescale 1ns / 1ps
module srvn_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [srvn_pkg::DVD_W-1:0] dividend,
    input  logic [srvn_pkg::DSR_W-1:0] divisor,
    output logic [srvn_pkg::DVD_W-1:0] quotient,
    output logic                      busy,
    output logic                      done
);
    import srvn_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   shifted;
    logic             ge;

    // Shift in one dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DSR_W'(shifted - {1'b0, dsr_reg}) : shifted[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

[rtl/core/srvn_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module srvn_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [srvn_pkg::RAD_W-1:0]  radicand,
    output logic [srvn_pkg::ROOT_W-1:0] root,
    output logic                       done
);
    import srvn_pkg::*;

    localparam int CW  = $clog2(ROOT_W);
    localparam int RMW = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [RMW-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RMW+1:0]    rem_sh;
    logic [RMW+1:0]    trial;
    logic              ge;

    // Bring down two radicand bits and test root*4+1
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? RMW'(rem_sh - trial) : rem_sh[RMW-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[rtl/core/srvn_dp.sv]
// Datapath: statistics memory, working registers, multiplier, divider, square root.
`timescale 1ns / 1ps
module srvn_dp #(
    parameter int FEATURES = srvn_pkg::FEATURES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  srvn_pkg::srvn_cmd_t        cmd,
    output srvn_pkg::srvn_status_t     status,
    input  logic [srvn_pkg::EPS_W-1:0] epsilon,
    input  srvn_pkg::srvn_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output srvn_pkg::srvn_out_t        m_data
);
    import srvn_pkg::*;

    localparam int AW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int MCW = $clog2(MAG_W + 1);

    // Statistics memory and its clearing sweep
    srvn_entry_t     mem [0:FEATURES-1];
    srvn_entry_t     rd_entry_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic            clr_done_reg;

    // Item and working registers
    srvn_in_t          item_reg;
    logic [AW-1:0]     addr_reg;
    logic              in_range_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [DATA_W-1:0] mean_reg;
    logic [M2_W-1:0]   m2_reg;
    logic [VAR_W-1:0]  s_reg;
    logic [MAG_W-1:0]  dmag_reg;
    logic              dneg_reg;

    // Shift-add multiplier
    logic [MAG_W-1:0]  mul_a_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [MCW-1:0]    mul_cnt_reg;
    logic              mul_busy_reg;
    logic              mul_done_reg;
    logic [MAG_W:0]    mul_sum;

    // Output register
    srvn_out_t out_reg;
    logic      m_valid_reg;
    logic      out_busy;

    // Shared units
    logic [DVD_W-1:0]  div_dvd;
    logic [DSR_W-1:0]  div_dsr;
    logic [DVD_W-1:0]  div_quo;
    logic              div_busy;
    logic              div_done;
    logic [ROOT_W-1:0] sd;
    logic              sqrt_done;

    // Preparation values
    srvn_entry_t       ent;
    logic [CNT_W-1:0]  n_inc;
    logic [MAG_W-1:0]  d_full;
    logic [VAR_W:0]    s_sum;
    logic              in_range_in;

    // Mean update values
    logic [MAG_W:0]    mean_ext;
    logic [MAG_W:0]    mean_new_ext;
    logic [DATA_W-1:0] mean_new;
    logic [MAG_W-1:0]  d1_full;
    logic [MAG_W-1:0]  d1_mag;

    // Write-back and result values
    logic [M2_W:0]     m2_sum;
    logic [VAR_W-1:0]  var_sat;
    srvn_entry_t       wr_entry;
    srvn_out_t         res;

    assign in_range_in = {22'd0, s_data.feature} < 32'(FEATURES);

    // Pick the statistics of the item's feature, zeros when out of range
    always_comb begin
        ent    = in_range_reg ? rd_entry_reg : '0;
        n_inc  = (ent.count == '1) ? ent.count : ent.count + 1'b1;
        d_full = {item_reg.sample[DATA_W-1], item_reg.sample}
               - {ent.mean[DATA_W-1], ent.mean};
        s_sum  = {1'b0, ent.variance} + (VAR_W + 1)'(epsilon);
    end

    // Move the mean by the quotient toward the sample
    always_comb begin
        mean_ext     = {{2{mean_reg[DATA_W-1]}}, mean_reg};
        mean_new_ext = dneg_reg ? mean_ext - {1'b0, div_quo[MAG_W-1:0]}
                                : mean_ext + {1'b0, div_quo[MAG_W-1:0]};
        mean_new     = mean_new_ext[DATA_W-1:0];
        d1_full      = {item_reg.sample[DATA_W-1], item_reg.sample}
                     - {mean_new[DATA_W-1], mean_new};
        d1_mag       = d1_full[MAG_W-1] ? -d1_full : d1_full;
    end

    // Saturating m2 sum and variance
    assign m2_sum  = {1'b0, m2_reg} + (M2_W + 1)'(prod_reg[PROD_W-1:FRAC_W]);
    assign var_sat = (|div_quo[DVD_W-1:VAR_W]) ? '1 : div_quo[VAR_W-1:0];

    always_comb begin
        wr_entry.count    = n_reg;
        wr_entry.mean     = mean_reg;
        wr_entry.m2       = m2_reg;
        wr_entry.variance = var_sat;
    end

    // Select the divider operands
    always_comb begin
        unique case (cmd.div_sel)
            DIV_MEAN: begin
                div_dvd = DVD_W'(dmag_reg);
                div_dsr = n_reg;
            end
            DIV_VAR: begin
                div_dvd = m2_reg;
                div_dsr = n_reg;
            end
            DIV_NORM: begin
                div_dvd = DVD_W'({dmag_reg, {FRAC_W{1'b0}}});
                div_dsr = sd;
            end
            default: begin
                div_dvd = '0;
                div_dsr = '0;
            end
        endcase
    end

    // Turn the quotient into a signed result, clip and flag
    always_comb begin
        res.normalized = '0;
        res.saturated  = 1'b0;
        if (dmag_reg == '0) begin
            res.normalized = '0;
        end else if (sd == '0) begin
            res.saturated  = 1'b1;
            res.normalized = dneg_reg ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
        end else if (dneg_reg) begin
            if (div_quo > DVD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
                res.saturated  = 1'b1;
                res.normalized = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                res.normalized = -div_quo[DATA_W-1:0];
            end
        end else begin
            if (div_quo > DVD_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
                res.saturated  = 1'b1;
                res.normalized = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                res.normalized = div_quo[DATA_W-1:0];
            end
        end
    end

    // Memory: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.wr) begin
            mem[addr_reg] <= wr_entry;
        end
        rd_entry_reg <= mem[addr_reg];
    end

    // Advance the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_done_reg <= 1'b0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (status.clr_last) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // Capture the item and update the working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg     <= s_data;
            addr_reg     <= AW'(s_data.feature);
            in_range_reg <= in_range_in;
        end
        if (cmd.prep) begin
            n_reg    <= n_inc;
            mean_reg <= ent.mean;
            m2_reg   <= ent.m2;
            s_reg    <= s_sum[VAR_W] ? '1 : s_sum[VAR_W-1:0];
            dneg_reg <= d_full[MAG_W-1];
            dmag_reg <= d_full[MAG_W-1] ? -d_full : d_full;
        end
        if (cmd.mean_upd) begin
            mean_reg <= mean_new;
        end
        if (cmd.m2_upd) begin
            m2_reg <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
        end
    end

    // Multiplier: add the multiplicand for each low bit, then shift right
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:MAG_W]}
                   + (prod_reg[0] ? {1'b0, mul_a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else begin
            mul_done_reg <= 1'b0;
            if (cmd.mean_upd) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end else if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MCW'(MAG_W - 1)) begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
        if (cmd.mean_upd) begin
            mul_a_reg <= dmag_reg;
            prod_reg  <= {{MAG_W{1'b0}}, d1_mag};
        end else if (mul_busy_reg) begin
            prod_reg <= {mul_sum, prod_reg[MAG_W-1:1]};
        end
    end

    // Hold the result until the item is taken
    assign out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.res_load) begin
            out_reg <= res;
        end
    end

    srvn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    srvn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.sqrt_start),
        .radicand ({s_reg, {FRAC_W{1'b0}}}),
        .root     (sd),
        .done     (sqrt_done)
    );

    always_comb begin
        status.clr_last  = clr_addr_reg == AW'(FEATURES - 1);
        status.acc       = item_reg.kind == KIND_ACC;
        status.in_range  = in_range_reg;
        status.div_done  = div_done;
        status.mul_done  = mul_done_reg;
        status.sqrt_done = sqrt_done;
        status.out_busy  = out_busy;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // No item enters before the memory sweep has finished
    a_load_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> clr_done_reg)
        else $error("item loaded before statistics were cleared");

    // Only in-range accumulate items write the memory
    a_write_acc_only: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> (in_range_reg && item_reg.kind == KIND_ACC))
        else $error("memory write for a normalize or out-of-range item");

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> !out_busy)
        else $error("result overwritten before it was taken");

    // The divider is started only when free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // The multiplier flags done only at the end of a run
    a_mul_len: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done_reg |-> !mul_busy_reg && $past(mul_busy_reg))
        else $error("multiplier done without running");

endmodule

[rtl/core/srvn_ctrl.sv]
// Controller: sequences clearing, accumulate and normalize items over the datapath.
`timescale 1ns / 1ps
module srvn_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output srvn_pkg::srvn_cmd_t    cmd,
    input  srvn_pkg::srvn_status_t status
);
    import srvn_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MEAN,
        ST_MUL_WAIT,
        ST_M2,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_WRITE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_NORM_GO,
        ST_NORM_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   res_pending_reg, res_pending_next;

    // Next state and commands
    always_comb begin
        state_next       = state_reg;
        res_pending_next = res_pending_reg;
        cmd              = '0;
        cmd.div_sel      = DIV_MEAN;
        s_ready          = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Finish a waiting result before taking the next item
                if (res_pending_reg) begin
                    if (!status.out_busy) begin
                        cmd.res_load     = 1'b1;
                        res_pending_next = 1'b0;
                    end
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                if (!status.acc) begin
                    state_next = ST_SQRT_GO;
                end else if (status.in_range) begin
                    state_next = ST_MEAN_GO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                cmd.mean_upd = 1'b1;
                state_next   = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                if (status.mul_done) begin
                    state_next = ST_M2;
                end
            end
            ST_M2: begin
                cmd.m2_upd = 1'b1;
                state_next = ST_VAR_GO;
            end
            ST_VAR_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_VAR;
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                cmd.div_sel = DIV_VAR;
                if (status.div_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (status.sqrt_done) begin
                    state_next = ST_NORM_GO;
                end
            end
            ST_NORM_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NORM;
                state_next    = ST_NORM_WAIT;
            end
            ST_NORM_WAIT: begin
                cmd.div_sel = DIV_NORM;
                if (status.div_done) begin
                    // Load now if the output is free, else hold it for idle
                    if (!status.out_busy) begin
                        cmd.res_load = 1'b1;
                    end else begin
                        res_pending_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            res_pending_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            res_pending_reg <= res_pending_next;
        end
    end

endmodule

[rtl/core/sparse_running_variance_normalizer.sv]
// Top level: configuration register, controller and datapath of the normalizer.
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_data  (kind, feature, sample)
//  m_        out        m_valid / m_ready   m_data  (normalized, saturated)
//  apb       in         psel/penable/pready paddr, pwdata, prdata (epsilon)
//
//  In-range accumulate item: two 64-step divisions and a 33-step multiply.
//  Normalize item: a 32-step square root and a 64-step division.
//  One item is worked at a time; a finished result waits in the output register
//  while the next item is taken and holds back the following result, which then
//  stalls the input until it is loaded. After reset the statistics memory is
//  cleared entry by entry; no item is taken until then.
`timescale 1ns / 1ps
module sparse_running_variance_normalizer #(
    parameter int FEATURES = srvn_pkg::FEATURES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  srvn_pkg::srvn_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output srvn_pkg::srvn_out_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srvn_pkg::APB_AW-1:0] paddr,
    input  logic [srvn_pkg::APB_DW-1:0] pwdata,
    output logic [srvn_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import srvn_pkg::*;

    logic [EPS_W-1:0] eps_reg;
    logic             reg_sel;
    srvn_cmd_t        cmd;
    srvn_status_t     status;

    // Decode the register index from the word address
    assign reg_sel = paddr[APB_AW-1:2] == 1'(REG_EPSILON);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DW'(eps_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    srvn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    srvn_dp #(
        .FEATURES (FEATURES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .epsilon (eps_reg),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
